/* rtl/stec_pkg.sv */
// Shared types and constants for the source text encoding checker.
`default_nettype none

package stec_pkg;

  // Default width of the line counter.
  localparam int LINE_BITS_DEF = 32;

  // Width of the reported line number field.
  localparam int LINE_OUT_BITS = 32;

  // Number of incident kinds that keep a first-seen flag.
  localparam int SEEN_BITS = 5;

  // Result slots that one input byte can fill.
  localparam int RES_SLOTS = 3;

  // Byte codes and the control-character limit.
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;

  // Parser state.
  typedef enum logic [2:0] {
    ST_NORMAL = 3'd0,
    ST_BOL    = 3'd1,
    ST_CR     = 3'd2,
    ST_EXP3   = 3'd3,
    ST_EXP2   = 3'd4,
    ST_EXP1   = 3'd5
  } pst_t;

  // Incident kinds as reported on the output.
  typedef enum logic [2:0] {
    K_TAB   = 3'd0,
    K_CRLF  = 3'd1,
    K_CR    = 3'd2,
    K_CTRL  = 3'd3,
    K_BADMB = 3'd4,
    K_NOEOL = 3'd5,
    K_CLEAN = 3'd6
  } kind_t;

  // One result item without its end-of-run marker.
  typedef struct packed {
    kind_t                     kind;
    logic [LINE_OUT_BITS-1:0]  line;
    logic                      first;
  } result_t;

  // One-hot mask for a kind that keeps a first-seen flag.
  function automatic logic [SEEN_BITS-1:0] kind_mask(input kind_t kind);
    return SEEN_BITS'(1) << kind;
  endfunction

endpackage

`default_nettype wire

/* rtl/source_text_encoding_checker_core.sv */
// Top level of the source text encoding checker: input register, parser state, result buffer.
//
//   channel  direction  tdata                           tuser              tlast
//   s_*      in         [7:0] data_byte                 -                  end_of_file
//   m_*      out        [31:0] line_number, [32] first  [2:0] incident_kind last_of_run
//
// A byte is held in the input register, then is parsed combinationally into
// a buffer of up to three results, from which its results are offered in order.
// Bytes with at most one result stream at one per cycle while the output is not stalled;
// a byte with more results holds the output for each of them, while the next byte
// waits in the input register and the input stalls until its last result drains.
// rst is synchronous and returns the parser to the beginning of a line, line count zero.
// Stalls on the output back up through the result buffer into the input register.
`default_nettype none

module source_text_encoding_checker_core #(
  parameter int LINE_BITS = stec_pkg::LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] line_number, [32] first_of_kind, [39:33] zero
  output logic [2:0]  m_tuser,   // [2:0] incident_kind
  output logic        m_tlast    // last_of_run
);
  import stec_pkg::*;

  // Input register.
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_eof;

  // Parser state.
  pst_t                 pst, pst_next;
  logic [LINE_BITS-1:0] line_cnt, line_cnt_next;
  logic [SEEN_BITS-1:0] seen, seen_next;

  // Result buffer.
  result_t    res_buf [RES_SLOTS];
  logic [1:0] res_cnt;
  logic [1:0] res_idx;
  result_t    step_res [RES_SLOTS];
  logic [1:0] step_cnt;
  result_t    head;

  logic drain, buf_free, load, take;

  stec_step #(
    .LINE_BITS(LINE_BITS)
  ) u_step (
    .pst           (pst),
    .line_cnt      (line_cnt),
    .seen          (seen),
    .data_byte     (in_byte),
    .end_of_file   (in_eof),
    .pst_next      (pst_next),
    .line_cnt_next (line_cnt_next),
    .seen_next     (seen_next),
    .res_cnt       (step_cnt),
    .res           (step_res)
  );

  // Handshake control.
  assign drain    = m_tvalid && m_tready;
  assign buf_free = (res_cnt == 2'd0) || ((res_cnt == 2'd1) && drain);
  assign load     = in_full && buf_free;
  assign s_tready = !in_full || load;
  assign take     = s_tvalid && s_tready;

  // Output beat from the head of the result buffer.
  assign head     = res_buf[res_idx];
  assign m_tvalid = (res_cnt != 2'd0);
  assign m_tdata  = {7'd0, head.first, head.line};
  assign m_tuser  = head.kind;
  assign m_tlast  = (res_cnt == 2'd1);

  // Control and parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      res_cnt  <= 2'd0;
      res_idx  <= 2'd0;
      pst      <= ST_BOL;
      line_cnt <= '0;
      seen     <= '0;
    end else begin
      if (take) begin
        in_full <= 1'b1;
      end else if (load) begin
        in_full <= 1'b0;
      end
      if (load) begin
        res_cnt  <= step_cnt;
        res_idx  <= 2'd0;
        pst      <= pst_next;
        line_cnt <= line_cnt_next;
        seen     <= seen_next;
      end else if (drain) begin
        res_cnt <= res_cnt - 2'd1;
        res_idx <= res_idx + 2'd1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take) begin
      in_byte <= s_tdata;
      in_eof  <= s_tlast;
    end
    if (load) begin
      res_buf <= step_res;
    end
  end

`ifndef SYNTHESIS
  // A parsed end-of-file byte leaves the parser in its reset state.
  a_eof_resets: assert property (@(posedge clk) disable iff (rst)
    load && in_eof |=> (pst == ST_BOL) && (line_cnt == '0) && (seen == '0))
    else $error("parser state not cleared after end of file");

  // End-of-file results always close their run.
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == K_NOEOL || m_tuser == K_CLEAN) |-> m_tlast)
    else $error("end-of-file result not last of run");

  // The buffer read position never runs past its depth.
  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, res_idx} + {1'b0, res_cnt}) <= 3'd3)
    else $error("result buffer overrun");

  // Line numbers do not decrease within one run.
  a_line_order: assert property (@(posedge clk) disable iff (rst)
    drain && !m_tlast |=> m_tvalid && (m_tdata[31:0] >= $past(m_tdata[31:0])))
    else $error("line number decreased within a run");
`endif

endmodule

`default_nettype wire

/* rtl/stec_step.sv */
// Combinational parser step: one byte against the current state.
`default_nettype none

module stec_step #(
  parameter int LINE_BITS = stec_pkg::LINE_BITS_DEF
) (
  input  stec_pkg::pst_t                     pst,
  input  logic [LINE_BITS-1:0]               line_cnt,
  input  logic [stec_pkg::SEEN_BITS-1:0]     seen,
  input  logic [7:0]                         data_byte,
  input  logic                               end_of_file,
  output stec_pkg::pst_t                     pst_next,
  output logic [LINE_BITS-1:0]               line_cnt_next,
  output logic [stec_pkg::SEEN_BITS-1:0]     seen_next,
  output logic [1:0]                         res_cnt,
  output stec_pkg::result_t                  res [stec_pkg::RES_SLOTS]
);
  import stec_pkg::*;

  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
  localparam int WIDE = (LINE_BITS > LINE_OUT_BITS) ? LINE_BITS : LINE_OUT_BITS;

  // Saturating increment of the line counter.
  function automatic logic [LINE_BITS-1:0] sat_inc(input logic [LINE_BITS-1:0] v);
    return (v == LINE_MAX) ? v : v + LINE_BITS'(1);
  endfunction

  // One-based line number, clamped to the output field.
  function automatic logic [LINE_OUT_BITS-1:0] report(input logic [LINE_BITS-1:0] v);
    logic [WIDE-1:0] w;
    w = WIDE'(sat_inc(v));
    if (w > WIDE'({LINE_OUT_BITS{1'b1}})) begin
      return '1;
    end
    return w[LINE_OUT_BITS-1:0];
  endfunction

  logic is_lf, is_cr, is_tab, trailer, lead4, lead3, lead2, is_ctrl;
  logic a_valid, b_valid, do_plain;
  kind_t a_kind, b_kind, c_kind;
  pst_t pst_a, pst_b;
  logic [LINE_BITS-1:0] cnt_a, cnt_b;
  result_t r_a, r_b, r_c;

  // Byte class decode.
  assign is_lf   = (data_byte == CH_LF);
  assign is_cr   = (data_byte == CH_CR);
  assign is_tab  = (data_byte == CH_TAB);
  assign trailer = (data_byte[7:6] == 2'b10);
  assign lead4   = (data_byte[7:3] == 5'b11110);
  assign lead3   = (data_byte[7:4] == 4'b1110);
  assign lead2   = (data_byte[7:5] == 3'b110);
  assign is_ctrl = (data_byte < CH_CTRL_LIMIT);

  // State carried over from a CR or an open multibyte sequence.
  always_comb begin
    a_valid  = 1'b0;
    a_kind   = K_BADMB;
    do_plain = 1'b0;
    pst_a    = pst;
    cnt_a    = line_cnt;
    case (pst)
      ST_CR: begin
        a_valid  = 1'b1;
        a_kind   = is_lf ? K_CRLF : K_CR;
        cnt_a    = sat_inc(line_cnt);
        pst_a    = ST_BOL;
        do_plain = !is_lf;
      end
      ST_EXP3, ST_EXP2, ST_EXP1: begin
        if (trailer) begin
          case (pst)
            ST_EXP3: pst_a = ST_EXP2;
            ST_EXP2: pst_a = ST_EXP1;
            default: pst_a = ST_NORMAL;
          endcase
        end else begin
          a_valid = 1'b1;
          a_kind  = K_BADMB;
          pst_a   = ST_NORMAL;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase
  end

  // Examination of a byte at the beginning of a line or mid-line.
  always_comb begin
    b_valid = 1'b0;
    b_kind  = K_TAB;
    pst_b   = pst_a;
    cnt_b   = cnt_a;
    if (do_plain) begin
      pst_b = ST_NORMAL;
      if (is_lf) begin
        cnt_b = sat_inc(cnt_a);
        pst_b = ST_BOL;
      end else if (is_cr) begin
        pst_b = ST_CR;
      end else if (is_tab) begin
        b_valid = 1'b1;
        b_kind  = K_TAB;
      end else if (lead4) begin
        pst_b = ST_EXP3;
      end else if (lead3) begin
        pst_b = ST_EXP2;
      end else if (lead2) begin
        pst_b = ST_EXP1;
      end else if (trailer) begin
        b_valid = 1'b1;
        b_kind  = K_BADMB;
      end else if (is_ctrl) begin
        b_valid = 1'b1;
        b_kind  = K_CTRL;
      end
    end
  end

  assign c_kind = (pst_b != ST_BOL) ? K_NOEOL : K_CLEAN;

  // Next state; end of file returns everything to its reset values.
  always_comb begin
    if (end_of_file) begin
      pst_next      = ST_BOL;
      line_cnt_next = '0;
      seen_next     = '0;
    end else begin
      pst_next      = pst_b;
      line_cnt_next = cnt_b;
      seen_next     = seen | (a_valid ? kind_mask(a_kind) : '0)
                           | (b_valid ? kind_mask(b_kind) : '0);
    end
  end

  // Result items in emission order, packed toward slot zero.
  always_comb begin
    r_a.kind  = a_kind;
    r_a.line  = report(line_cnt);
    r_a.first = ((seen & kind_mask(a_kind)) == '0);
    r_b.kind  = b_kind;
    r_b.line  = report(cnt_a);
    r_b.first = ((seen & kind_mask(b_kind)) == '0);
    r_c.kind  = c_kind;
    r_c.line  = report(cnt_b);
    r_c.first = 1'b1;
    res_cnt   = {1'b0, a_valid} + {1'b0, b_valid} + {1'b0, end_of_file};
    if (a_valid) begin
      res[0] = r_a;
      res[1] = b_valid ? r_b : r_c;
      res[2] = r_c;
    end else begin
      res[0] = b_valid ? r_b : r_c;
      res[1] = r_c;
      res[2] = r_c;
    end
  end

endmodule

`default_nettype wire
